// ----- src/fuut_pkg.sv -----
// Package for the first unique identifier tracker.
// Holds field widths, sighting class and seen count codes, and the control struct.
// No dependencies.
`default_nettype none

package fuut_pkg;

  localparam int unsigned ID_W         = 10;
  localparam int unsigned ID_COUNT_DEF = 1024;
  localparam int unsigned S_TDATA_W    = 16;
  localparam int unsigned M_TDATA_W    = 16;
  localparam int unsigned CLASS_W      = 2;
  localparam int unsigned COUNT_W      = 2;

  typedef logic [CLASS_W-1:0] sighting_class_t;
  localparam sighting_class_t CLASS_FIRST  = 2'd0;
  localparam sighting_class_t CLASS_SECOND = 2'd1;
  localparam sighting_class_t CLASS_REPEAT = 2'd2;

  typedef logic [COUNT_W-1:0] seen_count_t;
  localparam seen_count_t COUNT_NONE  = 2'd0;
  localparam seen_count_t COUNT_ONCE  = 2'd1;
  localparam seen_count_t COUNT_TWICE = 2'd2;

  // Write strobes and class produced by the list update logic.
  typedef struct packed {
    logic            count_we;
    logic            next_we;
    logic            prev_we;
    sighting_class_t cls;
  } upd_ctrl_t;

endpackage

`default_nettype wire

// ----- src/fuut_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module fuut_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/fuut_link_logic.sv -----
// Read-modify-write logic for the order list: classifies a sighting and works out
// the count and link writes and the new head, tail and empty flag. Uses fuut_pkg.
`default_nettype none

module fuut_link_logic
  import fuut_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic              in_range,
  input  wire seen_count_t       count_rd,
  input  wire logic [IDX_W-1:0]  prev_rd,
  input  wire logic [IDX_W-1:0]  next_rd,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [IDX_W-1:0]  head,
  input  wire logic [IDX_W-1:0]  tail,
  input  wire logic              empty,
  output upd_ctrl_t              ctrl,
  output seen_count_t            count_wdata,
  output logic      [IDX_W-1:0]  next_waddr,
  output logic      [IDX_W-1:0]  next_wdata,
  output logic      [IDX_W-1:0]  prev_waddr,
  output logic      [IDX_W-1:0]  prev_wdata,
  output logic      [IDX_W-1:0]  head_next,
  output logic      [IDX_W-1:0]  tail_next,
  output logic                   empty_next
);

  logic at_head;
  logic at_tail;

  assign at_head = (idx == head);
  assign at_tail = (idx == tail);

  always_comb begin
    ctrl        = '{count_we: 1'b0, next_we: 1'b0, prev_we: 1'b0, cls: CLASS_REPEAT};
    count_wdata = COUNT_ONCE;
    next_waddr  = tail;
    next_wdata  = idx;
    prev_waddr  = idx;
    prev_wdata  = tail;
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    priority if (in_range && count_rd == COUNT_NONE) begin
      // First sighting: append at the tail.
      ctrl.cls      = CLASS_FIRST;
      ctrl.count_we = 1'b1;
      count_wdata   = COUNT_ONCE;
      tail_next     = idx;
      if (empty) begin
        head_next  = idx;
        empty_next = 1'b0;
      end else begin
        ctrl.next_we = 1'b1;
        ctrl.prev_we = 1'b1;
      end
    end else if (in_range && count_rd == COUNT_ONCE) begin
      // Second sighting: unlink from the list.
      ctrl.cls      = CLASS_SECOND;
      ctrl.count_we = 1'b1;
      count_wdata   = COUNT_TWICE;
      next_waddr    = prev_rd;
      next_wdata    = next_rd;
      prev_waddr    = next_rd;
      prev_wdata    = prev_rd;
      if (at_head && at_tail) begin
        empty_next = 1'b1;
        head_next  = '0;
        tail_next  = '0;
      end else begin
        if (at_head) begin
          head_next = next_rd;
        end else begin
          ctrl.next_we = 1'b1;
        end
        if (at_tail) begin
          tail_next = prev_rd;
        end else begin
          ctrl.prev_we = 1'b1;
        end
      end
    end else begin
      ctrl.cls = CLASS_REPEAT;
    end
  end

endmodule

`default_nettype wire

// ----- src/first_unique_id_tracker_unit.sv -----
// First unique identifier tracker, top level. Uses fuut_pkg, fuut_ram, fuut_link_logic.
// Flow: an accepted item's count and link reads land in the RAM output registers, and its
// result is then registered in the output register once that register is free.
// One item at a time: a new item is accepted only after the previous one has been written
// back and its result taken into the output register; a stalled output holds it off.
// Reset: rst (synchronous, active high) clears control state, then a clearing pass
// zeroes every seen count; no item is accepted until it ends.
`default_nettype none

module first_unique_id_tracker_unit
  import fuut_pkg::*;
#(
  parameter int unsigned ID_COUNT = ID_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // [9:0] visitor_id
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata   // [1:0] sighting_class, [2] oldest_valid,
                                              // [12:3] oldest_id
);

  localparam int unsigned IDX_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

  // The block steps through three phases. While clearing it writes zero into one
  // seen-count entry per cycle. In idle it waits for an item and launches the
  // memory reads. In the calculate phase the read data is back, the list update
  // is worked out and written, and the result goes to the output register once
  // that register is free.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CALC  = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_in_range;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic             empty;

  logic            out_valid;
  sighting_class_t out_class;
  logic            out_oldest_valid;
  logic [ID_W-1:0] out_oldest_id;

  logic             in_accept;
  logic             commit;
  logic [ID_W-1:0]  in_id;
  logic [IDX_W-1:0] in_idx;

  seen_count_t      count_rd;
  logic [IDX_W-1:0] prev_rd;
  logic [IDX_W-1:0] next_rd;

  upd_ctrl_t        ctrl;
  seen_count_t      count_wdata;
  logic [IDX_W-1:0] next_waddr;
  logic [IDX_W-1:0] next_wdata;
  logic [IDX_W-1:0] prev_waddr;
  logic [IDX_W-1:0] prev_wdata;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic             empty_next;

  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  seen_count_t      cnt_wdata;

  assign in_id     = s_tdata[ID_W-1:0];
  assign in_idx    = IDX_W'(in_id);
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  // The update is written back only when the output register can take the result,
  // so the read data stays parked in the memory output registers during a stall.
  assign commit    = (state == ST_CALC) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == IDX_W'(ID_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      head    <= '0;
      tail    <= '0;
      empty   <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (commit) begin
        head  <= head_next;
        tail  <= tail_next;
        empty <= empty_next;
      end
    end
  end

  // Item payload captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_idx      <= in_idx;
      cur_in_range <= (32'(in_id) < 32'(ID_COUNT));
    end
  end

  // The clearing pass owns the count memory write port until it ends.
  always_comb begin
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
      cnt_wdata = COUNT_NONE;
    end else begin
      cnt_we    = commit && ctrl.count_we;
      cnt_waddr = cur_idx;
      cnt_wdata = count_wdata;
    end
  end

  fuut_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (ID_COUNT),
    .AW    (IDX_W)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (count_rd)
  );

  fuut_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ID_COUNT),
    .AW    (IDX_W)
  ) u_prev_ram (
    .clk   (clk),
    .we    (commit && ctrl.prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (prev_rd)
  );

  fuut_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ID_COUNT),
    .AW    (IDX_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (commit && ctrl.next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (next_rd)
  );

  fuut_link_logic #(
    .IDX_W (IDX_W)
  ) u_link_logic (
    .in_range    (cur_in_range),
    .count_rd    (count_rd),
    .prev_rd     (prev_rd),
    .next_rd     (next_rd),
    .idx         (cur_idx),
    .head        (head),
    .tail        (tail),
    .empty       (empty),
    .ctrl        (ctrl),
    .count_wdata (count_wdata),
    .next_waddr  (next_waddr),
    .next_wdata  (next_wdata),
    .prev_waddr  (prev_waddr),
    .prev_wdata  (prev_wdata),
    .head_next   (head_next),
    .tail_next   (tail_next),
    .empty_next  (empty_next)
  );

  // Output register. The oldest identifier is the head after this item's update.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_class        <= ctrl.cls;
      out_oldest_valid <= !empty_next;
      out_oldest_id    <= empty_next ? '0 : ID_W'(head_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_oldest_id, out_oldest_valid, out_class});

endmodule

`default_nettype wire

// ----- src/fuut_checker.sv -----
// Port-level checker for the first unique identifier tracker, bound to the top level.
// Uses fuut_pkg.
`default_nettype none

module fuut_checker
  import fuut_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TDATA_W-1:0] s_tdata,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result pending right after reset");

  // One item at a time: no acceptance in the cycle after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // The class code is one of the three defined values and padding is zero.
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == CLASS_FIRST || m_tdata[1:0] == CLASS_SECOND ||
                   m_tdata[1:0] == CLASS_REPEAT) && m_tdata[15:13] == 3'd0))
    else $error("bad class code or padding");

  // With no identifier seen exactly once the oldest field reads zero, and a first
  // sighting always leaves the list non-empty.
  a_oldest_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[2] || m_tdata[12:3] == 10'd0) &&
                  (m_tdata[1:0] != CLASS_FIRST || m_tdata[2])))
    else $error("oldest identifier inconsistent with its valid flag");

endmodule

bind first_unique_id_tracker_unit fuut_checker u_fuut_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
